@@ design/assert_macros.svh @@
// assertion macros used by the bounding circle grow top design file
// depends on a clock named clk and a synchronous reset named rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define BCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bcg_pkg.sv @@
// shared constants and types for the bounding circle grow block
// no dependencies
package bcg_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] REG_GROW_MODE      = 2'd0;
  localparam logic [1:0] REG_START_CENTER_X = 2'd1;
  localparam logic [1:0] REG_START_CENTER_Y = 2'd2;
  localparam logic [1:0] REG_START_RADIUS   = 2'd3;

  localparam logic MODE_RECENTER = 1'b0;
  localparam logic MODE_EXPAND   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } bcg_sts_t;

endpackage

@@ design/bcg_mul.sv @@
// bit-serial shift-add multiplier with an addend, one multiplier bit per cycle
// depends on bcg_pkg
module bcg_mul #(
  parameter int W = bcg_pkg::COORD_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [W-1:0]     addend,
  output logic [2*W-1:0]   prod,
  output bcg_pkg::bcg_sts_t sts
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_hi;
  logic [W-1:0]     acc_lo;
  logic [W-1:0]     mcand;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [W:0]       sum;

  assign sum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mcand} : {(W + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_hi <= addend;
      acc_lo <= b;
      mcand  <= a;
    end else if (busy) begin
      acc_hi <= sum[W:1];
      acc_lo <= {sum[0], acc_lo[W-1:1]};
    end
  end

  assign prod = {acc_hi, acc_lo};
  assign sts  = '{busy: busy, done: done};

endmodule

@@ design/bcg_sqrt.sv @@
// digit-serial integer square root, one root bit per cycle
// depends on bcg_pkg
module bcg_sqrt #(
  parameter int N = bcg_pkg::COORD_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2*N-1:0]   radicand,
  output logic [N-1:0]     root,
  output bcg_pkg::bcg_sts_t sts
);

  localparam int CNT_W = $clog2(N + 1);

  logic [2*N-1:0]   rad;
  logic [N+1:0]     rem;
  logic [N-1:0]     root_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [N+1:0]     rem_sh;
  logic [N+1:0]     trial;
  logic             fits;

  assign rem_sh = {rem[N-1:0], rad[2*N-1:2*N-2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= radicand;
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      rad <= {rad[2*N-3:0], 2'b00};
      if (fits) begin
        rem    <= rem_sh - trial;
        root_r <= {root_r[N-2:0], 1'b1};
      end else begin
        rem    <= rem_sh;
        root_r <= {root_r[N-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign sts  = '{busy: busy, done: done};

endmodule

@@ design/bcg_div.sv @@
// restoring serial divider, one quotient bit per cycle
// depends on bcg_pkg; needs the upper half of num below den
module bcg_div #(
  parameter int N = bcg_pkg::COORD_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2*N-1:0]   num,
  input  logic [N:0]       den,
  output logic [N-1:0]     quo,
  output bcg_pkg::bcg_sts_t sts
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N:0]       rem;
  logic [N:0]       dvsr;
  logic [N-1:0]     qsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [N+1:0]     rem_sh;
  logic [N+1:0]     diff;
  logic             ge;

  assign rem_sh = {rem, qsh[N-1]};
  assign ge     = rem_sh >= {1'b0, dvsr};
  assign diff   = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num[2*N-1:N]};
      qsh  <= num[N-1:0];
      dvsr <= den;
    end else if (busy) begin
      rem <= ge ? diff[N:0] : rem_sh[N:0];
      qsh <= {qsh[N-2:0], ge};
    end
  end

  assign quo = qsh;
  assign sts = '{busy: busy, done: done};

endmodule

@@ design/bounding_circle_grow_top.sv @@
// Bounding circle grow: keeps a circle (center, radius) around a stream of signed fixed point
// points, reloading it from the start registers on a point flagged first, and either moves the
// center toward an outside point by half of its distance beyond the circle, the radius becoming
// the mean of that distance and the old radius (recenter mode), or stretches the radius to the
// point (expand mode). One result leaves for every point. Points are taken one at a time and the
// block is busy until the result is in the output register. The work is done by bit-serial units:
// the squares and the center offsets go through shift-add multipliers, the distance through a
// one-bit-per-cycle square root and the offset scaling through restoring dividers.
// depends on bcg_pkg, bcg_mul, bcg_sqrt, bcg_div and assert_macros.svh
`include "assert_macros.svh"

module bounding_circle_grow_top #(
  parameter int  COORD_BITS = bcg_pkg::COORD_BITS_DEF,
  localparam int APB_W  = (COORD_BITS >= 32) ? 64 : 32,
  localparam int ADDR_W = (COORD_BITS >= 32) ? 5 : 4,
  localparam int IN_W   = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((3 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // request in
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // point_x, point_y
  input  logic              s_tuser,   // first_point
  // result out
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // center_x, center_y, radius_out, grew
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam int C = COORD_BITS;
  localparam int N = COORD_BITS + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_DLAT = 4'd6;
  localparam logic [3:0] S_PROD = 4'd7;
  localparam logic [3:0] S_QUOT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [C-1:0] CMAX = {1'b0, {(C - 1){1'b1}}};
  localparam logic [C-1:0] CMIN = {1'b1, {(C - 1){1'b0}}};

  logic [3:0]     state;

  logic           grow_mode;
  logic [C-1:0]   start_cx;
  logic [C-1:0]   start_cy;
  logic [N-1:0]   start_r;
  logic [1:0]     reg_idx;

  logic [C-1:0]   cx;
  logic [C-1:0]   cy;
  logic [N-1:0]   cr;
  logic [C-1:0]   pt_x;
  logic [C-1:0]   pt_y;
  logic [N-1:0]   adx;
  logic [N-1:0]   ady;
  logic           sx;
  logic           sy;
  logic [2*N-1:0] sq;
  logic [N-1:0]   d;

  logic [C-1:0]   res_cx;
  logic [C-1:0]   res_cy;
  logic [N-1:0]   res_r;
  logic           res_grew;
  logic [C-1:0]   out_cx;
  logic [C-1:0]   out_cy;
  logic [N-1:0]   out_r;
  logic           out_grew;

  logic [N-1:0]   dx;
  logic [N-1:0]   dy;
  logic [N-1:0]   adx_c;
  logic [N-1:0]   ady_c;
  logic [N-1:0]   dmr;
  logic           outside;

  logic             sq_phase;
  logic             mul_go;
  logic [N-1:0]     m0_a, m0_b, m1_a, m1_b, m_add;
  logic [2*N-1:0]   prod0, prod1, prod2;
  bcg_pkg::bcg_sts_t mul0_sts, mul1_sts, mul2_sts;
  logic [N-1:0]     root;
  bcg_pkg::bcg_sts_t sqrt_sts;
  logic [N-1:0]     quo0, quo1;
  bcg_pkg::bcg_sts_t div0_sts, div1_sts;

  logic [N:0]     ncx_w;
  logic [N:0]     ncy_w;
  logic [C-1:0]   ncx;
  logic [C-1:0]   ncy;
  logic [N:0]     nr_sum;
  logic [N-1:0]   nr;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_mode <= bcg_pkg::MODE_RECENTER;
      start_cx  <= '0;
      start_cy  <= '0;
      start_r   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        bcg_pkg::REG_GROW_MODE:      grow_mode <= pwdata[0];
        bcg_pkg::REG_START_CENTER_X: start_cx  <= pwdata[C-1:0];
        bcg_pkg::REG_START_CENTER_Y: start_cy  <= pwdata[C-1:0];
        bcg_pkg::REG_START_RADIUS:   start_r   <= pwdata[N-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcg_pkg::REG_GROW_MODE:      prdata = APB_W'(grow_mode);
      bcg_pkg::REG_START_CENTER_X: prdata = APB_W'(start_cx);
      bcg_pkg::REG_START_CENTER_Y: prdata = APB_W'(start_cy);
      bcg_pkg::REG_START_RADIUS:   prdata = APB_W'(start_r);
    endcase
  end

  // offsets from the center
  assign dx    = {pt_x[C-1], pt_x} - {cx[C-1], cx};
  assign dy    = {pt_y[C-1], pt_y} - {cy[C-1], cy};
  assign adx_c = dx[N-1] ? (~dx + N'(1)) : dx;
  assign ady_c = dy[N-1] ? (~dy + N'(1)) : dy;
  assign dmr   = d - cr;
  assign outside = sq > prod2;

  // multipliers: squares first, then offset times (d - r) plus d
  assign sq_phase = (state == S_DIFF);
  assign mul_go   = sq_phase || (state == S_DLAT && grow_mode == bcg_pkg::MODE_RECENTER);
  assign m0_a  = sq_phase ? adx_c : adx;
  assign m0_b  = sq_phase ? adx_c : dmr;
  assign m1_a  = sq_phase ? ady_c : ady;
  assign m1_b  = sq_phase ? ady_c : dmr;
  assign m_add = sq_phase ? '0 : d;

  bcg_mul #(.W(N)) u_mul0 (
    .clk(clk), .rst(rst), .start(mul_go), .a(m0_a), .b(m0_b), .addend(m_add),
    .prod(prod0), .sts(mul0_sts)
  );

  bcg_mul #(.W(N)) u_mul1 (
    .clk(clk), .rst(rst), .start(mul_go), .a(m1_a), .b(m1_b), .addend(m_add),
    .prod(prod1), .sts(mul1_sts)
  );

  bcg_mul #(.W(N)) u_mul2 (
    .clk(clk), .rst(rst), .start(sq_phase), .a(cr), .b(cr), .addend('0),
    .prod(prod2), .sts(mul2_sts)
  );

  bcg_sqrt #(.N(N)) u_sqrt (
    .clk(clk), .rst(rst), .start(state == S_CMP && outside), .radicand(sq),
    .root(root), .sts(sqrt_sts)
  );

  bcg_div #(.N(N)) u_div0 (
    .clk(clk), .rst(rst), .start(state == S_PROD && mul0_sts.done), .num(prod0),
    .den({d, 1'b0}), .quo(quo0), .sts(div0_sts)
  );

  bcg_div #(.N(N)) u_div1 (
    .clk(clk), .rst(rst), .start(state == S_PROD && mul1_sts.done), .num(prod1),
    .den({d, 1'b0}), .quo(quo1), .sts(div1_sts)
  );

  // recentered circle with saturation
  assign ncx_w = sx ? ({cx[C-1], cx[C-1], cx} - {1'b0, quo0})
                    : ({cx[C-1], cx[C-1], cx} + {1'b0, quo0});
  assign ncy_w = sy ? ({cy[C-1], cy[C-1], cy} - {1'b0, quo1})
                    : ({cy[C-1], cy[C-1], cy} + {1'b0, quo1});
  assign ncx = ((ncx_w[C+1] != ncx_w[C]) || (ncx_w[C] != ncx_w[C-1]))
               ? (ncx_w[C+1] ? CMIN : CMAX) : ncx_w[C-1:0];
  assign ncy = ((ncy_w[C+1] != ncy_w[C]) || (ncy_w[C] != ncy_w[C-1]))
               ? (ncy_w[C+1] ? CMIN : CMAX) : ncy_w[C-1:0];
  assign nr_sum = {1'b0, d} + {1'b0, cr} + (N + 1)'(1);
  assign nr     = nr_sum[N:1];

  assign s_tready = (state == S_IDLE);

  // sequencer and circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cx    <= '0;
      cy    <= '0;
      cr    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              cx <= start_cx;
              cy <= start_cy;
              cr <= start_r;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SQ;
        S_SQ: begin
          if (mul0_sts.done) begin
            state <= S_SUM;
          end
        end
        S_SUM: state <= S_CMP;
        S_CMP: state <= outside ? S_ROOT : S_DONE;
        S_ROOT: begin
          if (sqrt_sts.done) begin
            state <= S_DLAT;
          end
        end
        S_DLAT: begin
          if (grow_mode == bcg_pkg::MODE_EXPAND) begin
            cr    <= d;
            state <= S_DONE;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul0_sts.done) begin
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          if (div0_sts.done) begin
            cx    <= ncx;
            cy    <= ncy;
            cr    <= nr;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working data
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      pt_x <= s_tdata[C-1:0];
      pt_y <= s_tdata[2*C-1:C];
    end
    if (state == S_DIFF) begin
      adx <= adx_c;
      ady <= ady_c;
      sx  <= dx[N-1];
      sy  <= dy[N-1];
    end
    if (state == S_SUM) begin
      sq <= prod0 + prod1;
    end
    if (state == S_ROOT && sqrt_sts.done) begin
      d <= (root == '0) ? N'(1) : root;
    end
    if (state == S_CMP && !outside) begin
      res_cx   <= cx;
      res_cy   <= cy;
      res_r    <= cr;
      res_grew <= 1'b0;
    end
    if (state == S_DLAT && grow_mode == bcg_pkg::MODE_EXPAND) begin
      res_cx   <= cx;
      res_cy   <= cy;
      res_r    <= d;
      res_grew <= (d != cr);
    end
    if (state == S_QUOT && div0_sts.done) begin
      res_cx   <= ncx;
      res_cy   <= ncy;
      res_r    <= nr;
      res_grew <= (ncx != cx) || (ncy != cy) || (nr != cr);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_cx   <= res_cx;
      out_cy   <= res_cy;
      out_r    <= res_r;
      out_grew <= res_grew;
    end
  end

  assign m_tdata = OUT_W'({out_grew, out_r, out_cy, out_cx});

  // checks
  `BCG_ASSERT(a_units_idle,
    (state != S_IDLE) || !(mul0_sts.busy || mul1_sts.busy || mul2_sts.busy ||
                           sqrt_sts.busy || div0_sts.busy || div1_sts.busy),
    "arithmetic unit busy while waiting for a request")
  `BCG_ASSERT_NEXT(a_radius_grows, state != S_IDLE, cr >= $past(cr),
    "radius shrank while working on a request")
  `BCG_ASSERT_NEXT(a_inside_no_grow, (state == S_CMP) && !outside, !res_grew,
    "point inside the circle flagged as growth")

endmodule

@@ sim/bounding_circle_grow_top_test.sv @@
// self-checking testbench for bounding_circle_grow_top: directed table, then random point sets
// over several register settings, each result checked against the table or a circle predictor
// depends on bcg_pkg and the bounding_circle_grow_top design files
`timescale 1ns / 100ps

module bounding_circle_grow_top_test;

  localparam int     IDLE_LIMIT   = 2000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     PHASES       = 14;
  localparam int     PHASE_POINTS = 124;
  localparam longint COORD_MAX    = 32767;
  localparam longint COORD_MIN    = -32768;
  localparam longint RAD_MAX      = 131071;

  typedef struct packed {
    logic               grew;
    logic [16:0]        radius;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
  } circle_t;

  typedef struct {
    logic               is_reg;
    logic [1:0]         reg_idx;
    int                 reg_val;
    logic               first;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               typed;
    circle_t            want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers and the circle
  logic               grow_expand = 1'b0;
  logic signed [15:0] load_cx     = '0;
  logic signed [15:0] load_cy     = '0;
  logic [16:0]        load_r      = '0;
  logic signed [15:0] ctr_x       = '0;
  logic signed [15:0] ctr_y       = '0;
  logic [16:0]        rad         = '0;

  circle_t  pending_circles[$];
  int       mismatches   = 0;
  int       results_seen = 0;
  dir_row_t dir_rows [24];

  bounding_circle_grow_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] clamp_coord(longint v);
    if (v > COORD_MAX) return 16'sh7fff;
    if (v < COORD_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

  // move of one center coordinate, rounded to nearest on the magnitude
  function automatic longint centre_step(longint delta, longint unsigned d,
                                         longint unsigned r);
    longint unsigned m;
    longint unsigned q;
    m = (delta < 0) ? longint'(-delta) : longint'(delta);
    q = (m * (d - r) + d) / (2 * d);
    return (delta < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic circle_t circle_predict(logic first, logic signed [15:0] px,
                                             logic signed [15:0] py);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned d;
    longint unsigned r;
    longint unsigned nr;
    circle_t         res;
    if (first) begin
      ctr_x = load_cx;
      ctr_y = load_cy;
      rad   = load_r;
    end
    res = '{1'b0, rad, ctr_y, ctr_x};
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    r  = rad;
    sq = dx * dx + dy * dy;
    if (sq > r * r) begin
      d = floor_sqrt(sq);
      if (d == 0) d = 1;
      if (grow_expand == bcg_pkg::MODE_EXPAND) begin
        nr = d;
      end else begin
        res.cx = clamp_coord(longint'(ctr_x) + centre_step(dx, d, r));
        res.cy = clamp_coord(longint'(ctr_y) + centre_step(dy, d, r));
        nr = (d + r + 1) >> 1;
      end
      if (nr > RAD_MAX) nr = RAD_MAX;
      res.radius = nr[16:0];
      res.grew = (res.cx != ctr_x) || (res.cy != ctr_y) || (res.radius != rad);
    end
    ctr_x = res.cx;
    ctr_y = res.cy;
    rad   = res.radius;
    return res;
  endfunction

  function automatic dir_row_t pt(logic first, int px, int py);
    dir_row_t row;
    row = '{default: '0};
    row.first = first;
    row.px = 16'(px);
    row.py = 16'(py);
    return row;
  endfunction

  function automatic dir_row_t pt_exp(logic first, int px, int py, int cx, int cy, int r,
                                      logic g);
    dir_row_t row;
    row = pt(first, px, py);
    row.typed = 1'b1;
    row.want = '{g, 17'(r), 16'(cy), 16'(cx)};
    return row;
  endfunction

  function automatic dir_row_t reg_row(logic [1:0] idx, int val);
    dir_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic logic signed [15:0] near_coord(logic signed [15:0] c, int span);
    return clamp_coord(longint'(c) + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [15:0] edge_coord();
    case ($urandom_range(0, 3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic void pick_point(output logic signed [15:0] px,
                                     output logic signed [15:0] py);
    int sel;
    int span;
    sel = $urandom_range(0, 9);
    span = int'(rad) + int'(rad) / 2 + 16;
    if (sel <= 3) begin
      px = 16'($urandom);
      py = 16'($urandom);
    end else if (sel <= 7) begin
      px = near_coord(ctr_x, span);
      py = near_coord(ctr_y, span);
    end else if (sel == 8) begin
      px = edge_coord();
      py = edge_coord();
    end else begin
      px = near_coord(ctr_x, 2);
      py = near_coord(ctr_y, 2);
    end
  endfunction

  // write access, then read back through the same select
  task automatic reg_write(logic [1:0] idx, int val);
    logic [31:0] wmask;
    logic [31:0] wval;
    case (idx)
      bcg_pkg::REG_GROW_MODE:    wmask = 32'h0000_0001;
      bcg_pkg::REG_START_RADIUS: wmask = 32'h0001_ffff;
      default:                   wmask = 32'h0000_ffff;
    endcase
    wval = val & wmask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wval;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & wmask) != wval) begin
      $error("register %0d readback expected %0h got %0h", idx, wval, prdata & wmask);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bcg_pkg::REG_GROW_MODE:      grow_expand = wval[0];
      bcg_pkg::REG_START_CENTER_X: load_cx = wval[15:0];
      bcg_pkg::REG_START_CENTER_Y: load_cy = wval[15:0];
      bcg_pkg::REG_START_RADIUS:   load_r = wval[16:0];
    endcase
  endtask

  task automatic send_point(logic first, logic signed [15:0] px, logic signed [15:0] py,
                            logic typed, circle_t want, int gap);
    circle_t pred;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= {py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = circle_predict(first, px, py);
    pending_circles.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_circles.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int                 n;
    int                 set_len;
    int                 sx;
    int                 sy;
    int                 sr;
    logic               first;
    logic               sender_calm;
    logic               mode;
    logic signed [15:0] px;
    logic signed [15:0] py;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    dir_rows = '{
      pt_exp(1, 0, 0, 0, 0, 0, 0),
      pt_exp(0, 256, 0, 128, 0, 128, 1),
      pt_exp(0, 128, 0, 128, 0, 128, 0),
      pt(0, 32767, 32767),
      pt(0, -32768, -32768),
      pt(0, -32768, 32767),
      pt(1, -32768, -32768),
      reg_row(bcg_pkg::REG_START_RADIUS, 1),
      pt_exp(1, 1, 1, 0, 0, 1, 0),
      reg_row(bcg_pkg::REG_GROW_MODE, bcg_pkg::MODE_EXPAND),
      pt_exp(1, 256, 0, 0, 0, 256, 1),
      pt_exp(0, 0, -32768, 0, 0, 32768, 1),
      pt(0, 32767, 32767),
      pt_exp(1, 1, 1, 0, 0, 1, 0),
      reg_row(bcg_pkg::REG_START_CENTER_X, 32767),
      reg_row(bcg_pkg::REG_START_CENTER_Y, -32768),
      reg_row(bcg_pkg::REG_START_RADIUS, 131071),
      pt_exp(1, -32768, 32767, 32767, -32768, 131071, 0),
      pt(0, 32767, -32768),
      reg_row(bcg_pkg::REG_START_RADIUS, 0),
      reg_row(bcg_pkg::REG_GROW_MODE, bcg_pkg::MODE_RECENTER),
      pt(1, -32768, 32767),
      pt(0, 32767, -32768),
      pt(0, 0, 0)
    };
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        drain_block();
        reg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_point(dir_rows[i].first, dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed,
                   dir_rows[i].want, $urandom_range(0, 15));
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      mode = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      case (p)
        0: begin
          sx = 32767;
          sy = -32768;
          sr = 0;
        end
        1: begin
          sx = -32768;
          sy = 32767;
          sr = 131071;
        end
        default: begin
          sx = $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) - 32768
                                    : int'($urandom_range(0, 1023)) - 512;
          sy = $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) - 32768
                                    : int'($urandom_range(0, 1023)) - 512;
          sr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                           : $urandom_range(0, 4095);
          if (p == 2) sr = 1;
        end
      endcase
      reg_write(bcg_pkg::REG_GROW_MODE, int'(mode));
      reg_write(bcg_pkg::REG_START_CENTER_X, sx);
      reg_write(bcg_pkg::REG_START_CENTER_Y, sy);
      reg_write(bcg_pkg::REG_START_RADIUS, sr);
      sender_calm = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_POINTS) begin
        set_len = $urandom_range(1, 24);
        for (int k = 0; k < set_len && n < PHASE_POINTS; k++) begin
          // mostly whole sets opened by a first point, with a few stray reloads
          if (k == 0) first = ($urandom_range(0, 7) != 0);
          else first = ($urandom_range(0, 39) == 0);
          pick_point(px, py);
          send_point(first, px, py, 1'b0, '0, sender_calm ? 0 : $urandom_range(0, 15));
          n++;
        end
      end
    end

    drain_block();
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int   stall;
    logic held;
    logic calm;
    held = 1'b0;
    calm = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 500) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
      calm = ((results_seen / 80) % 3 == 1);
    end
  end

  always @(posedge clk) begin
    circle_t got;
    circle_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[49:0];
      results_seen++;
      if (pending_circles.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = pending_circles.pop_front();
        if (got.cx !== want.cx) begin
          $error("center_x expected %0d got %0d", want.cx, got.cx);
          mismatches++;
        end
        if (got.cy !== want.cy) begin
          $error("center_y expected %0d got %0d", want.cy, got.cy);
          mismatches++;
        end
        if (got.radius !== want.radius) begin
          $error("radius_out expected %0d got %0d", want.radius, got.radius);
          mismatches++;
        end
        if (got.grew !== want.grew) begin
          $error("grew expected %0d got %0d", want.grew, got.grew);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
